/* rtl/core/queued_sine_tone_generator_unit_macros.svh */
// Assertion macros shared by the queued sine tone generator RTL.
`ifndef QUEUED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH
`define QUEUED_SINE_TONE_GENERATOR_UNIT_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define QSTG_CHECK_NOW(lbl, ck, rs, trig, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (trig) |-> (cond)) \
    else $error("qstg same-cycle check failed");

// Check that a condition holds in the cycle after its trigger.
`define QSTG_CHECK_NEXT(lbl, ck, rs, trig, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (trig) |=> (cond)) \
    else $error("qstg next-cycle check failed");

`endif

/* rtl/core/qstg_pkg.sv */
// Package: types, constants, sine table and helpers of the queued tone generator.
`timescale 1ns / 1ps
`default_nettype none

package qstg_pkg;

  localparam int QUEUE_DEPTH     = 8;
  localparam int SAMPLE_RATE     = 44100;
  localparam int SINE_TABLE_SIZE = 1024;
  localparam int TONE_AMPLITUDE  = 28000;
  localparam int MS_PER_SECOND   = 1000;

  localparam int FREQ_W   = 15;
  localparam int DUR_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 22;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int PHASE_W = $clog2(SAMPLE_RATE);
  localparam int IDX_W   = $clog2(SINE_TABLE_SIZE);

  // Conditional subtracts needed to fold a 15-bit frequency below the sample rate.
  localparam int FREQ_FOLDS = ((2 ** FREQ_W) - 1) / SAMPLE_RATE;

  // Duration to sample count: floor(dur * SAMPLE_RATE / 1000) by reciprocal.
  localparam int DUR_SHIFT = 24;
  localparam longint unsigned DUR_RECIP =
    ((longint'(SAMPLE_RATE) << DUR_SHIFT) + longint'(MS_PER_SECOND) - 64'd1) /
    longint'(MS_PER_SECOND);
  localparam int DUR_RECIP_W = $clog2(DUR_RECIP + 64'd1);
  localparam int DUR_PROD_W  = DUR_W + DUR_RECIP_W;

  // Phase to table index: floor(phase * SINE_TABLE_SIZE / SAMPLE_RATE) by reciprocal.
  localparam int SINE_SHIFT = 34;
  localparam longint unsigned SINE_RECIP =
    ((longint'(SINE_TABLE_SIZE) << SINE_SHIFT) + longint'(SAMPLE_RATE) - 64'd1) /
    longint'(SAMPLE_RATE);
  localparam int SINE_RECIP_W = $clog2(SINE_RECIP + 64'd1);
  localparam int SINE_PROD_W  = PHASE_W + SINE_RECIP_W;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [FREQ_W-1:0] tone_freq;
    logic [DUR_W-1:0]  duration_ms;
    logic              reset_phase;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       accepted;
    logic                       playing;
  } res_t;

  // One queued tone: folded phase step and samples still to play.
  typedef struct packed {
    logic [FREQ_W-1:0]  step;
    logic [COUNT_W-1:0] left;
  } tone_t;

  localparam int TONE_W = $bits(tone_t);

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [SINE_TABLE_SIZE];

  // Quarter-wave folded Taylor series in Q30, scaled to the tone amplitude.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0]                f;
    logic [63:0]                r;
    logic [63:0]                x;
    logic [63:0]                x2;
    logic [63:0]                term;
    logic [63:0]                mag;
    longint                     sum;
    logic [1:0]                 quad;
    logic signed [SAMPLE_W-1:0] m;
    f    = (64'(k) << 32) / 64'(SINE_TABLE_SIZE);
    quad = f[31:30];
    r    = f & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    sum  = signed'(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    mag = (64'(sum) * 64'(TONE_AMPLITUDE) + 64'h10_0000) >> 30;
    if (mag > 64'(TONE_AMPLITUDE)) begin
      mag = 64'(TONE_AMPLITUDE);
    end
    m = SAMPLE_W'(mag);
    return quad[1] ? -m : m;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Fold a frequency into one phase step below the sample rate.
  function automatic logic [FREQ_W-1:0] fold_freq(input logic [FREQ_W-1:0] f);
    logic [FREQ_W-1:0] v;
    v = f;
    for (int i = 0; i < FREQ_FOLDS; i++) begin
      if (32'(v) >= SAMPLE_RATE) begin
        v = v - FREQ_W'(SAMPLE_RATE);
      end
    end
    return v;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/queued_sine_tone_generator_unit.sv */
// Top level of the queued sine tone generator: tone queue, phase accumulator, sine lookup.
// Pipeline: a taken command beat is registered into stage one, then into the output register.
// Throughput: one command per cycle unless stalled; the queue RAM head entry is read
//   every cycle and rewritten when a sample leaves it unspent, with last-write forwarding.
// Reset: synchronous rst clears queue pointers, fill count, phase and pipeline valids;
//   queue RAM contents stay undefined and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "queued_sine_tone_generator_unit_macros.svh"

module queued_sine_tone_generator_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output      logic          cmd_stall,
  input  wire qstg_pkg::cmd_t cmd,
  output      logic          res_valid,
  input  wire logic          res_stall,
  output      qstg_pkg::res_t res
);

  import qstg_pkg::*;

  // Queue control and phase state.
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   tail_next;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  // Queue RAM ports and write forwarding.
  logic               wr_en;
  logic [PTR_W-1:0]   wr_addr;
  tone_t              wr_tone;
  logic [TONE_W-1:0]  rd_word;
  tone_t              head_tone;
  logic               fwd_hit;
  tone_t              fwd_tone;

  // Pipeline: stage one holds the table index, the output register holds the beat.
  logic               take;
  logic               s1_open;
  logic               s2_open;
  logic               s1_valid;
  logic [IDX_W-1:0]   s1_idx;
  logic               s1_sine;
  logic               s1_accepted;
  logic               s1_playing;

  // Per-item datapath.
  logic                   is_push;
  logic                   full;
  logic                   empty;
  logic [DUR_PROD_W-1:0]  dur_prod;
  logic [COUNT_W-1:0]     push_count;
  logic [SINE_PROD_W-1:0] sine_prod;
  logic [IDX_W:0]         idx_wide;
  logic [IDX_W-1:0]       idx;
  logic [PHASE_W:0]       phase_sum;
  logic [PHASE_W-1:0]     phase_adv;
  logic [COUNT_W-1:0]     left_dec;
  logic                   pop;
  logic                   item_sine;
  logic                   item_accepted;

  // Handshake: the output register frees stage one, stage one frees the input.
  assign s2_open   = !res_valid || !res_stall;
  assign s1_open   = !s1_valid || s2_open;
  assign cmd_stall = !s1_open;
  assign take      = cmd_valid && !cmd_stall;

  assign is_push = (cmd.op == OP_PUSH);
  assign full    = (fill == FILL_W'(QUEUE_DEPTH));
  assign empty   = (fill == '0);

  // Sample count of a pushed tone, exact floor by reciprocal multiply.
  assign dur_prod   = DUR_PROD_W'(cmd.duration_ms) * DUR_PROD_W'(DUR_RECIP);
  assign push_count = COUNT_W'(dur_prod >> DUR_SHIFT);

  // Table index from the phase before this item advances it.
  assign sine_prod = SINE_PROD_W'(phase) * SINE_PROD_W'(SINE_RECIP);
  assign idx_wide  = (IDX_W + 1)'(sine_prod >> SINE_SHIFT);
  assign idx       = (idx_wide >= (IDX_W + 1)'(SINE_TABLE_SIZE)) ?
                     IDX_W'(SINE_TABLE_SIZE - 1) : idx_wide[IDX_W-1:0];

  // Head entry: RAM read issued last cycle, or last cycle's write to that entry.
  assign head_tone = fwd_hit ? fwd_tone : tone_t'(rd_word);

  // Advance the phase by the head step, wrap once at the sample rate.
  assign phase_sum = {1'b0, phase} + (PHASE_W + 1)'(head_tone.step);
  assign phase_adv = (phase_sum >= (PHASE_W + 1)'(SAMPLE_RATE)) ?
                     PHASE_W'(phase_sum - (PHASE_W + 1)'(SAMPLE_RATE)) :
                     PHASE_W'(phase_sum);

  assign left_dec = (head_tone.left != '0) ? head_tone.left - 1'b1 : head_tone.left;
  assign pop      = (left_dec == '0);

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    fill_next     = fill;
    phase_next    = phase;
    wr_en         = 1'b0;
    wr_addr       = tail;
    wr_tone       = '{step: fold_freq(cmd.tone_freq), left: push_count};
    item_sine     = 1'b0;
    item_accepted = 1'b0;
    if (take) begin
      if (is_push) begin
        // Queue the tone unless full; drop zero-length tones after the phase clear.
        if (!full) begin
          item_accepted = 1'b1;
          if (cmd.reset_phase) begin
            phase_next = '0;
          end
          if (push_count != '0) begin
            wr_en     = 1'b1;
            tail_next = ptr_inc(tail);
            fill_next = fill + 1'b1;
          end
        end
      end else if (!empty) begin
        // Play the head tone: advance phase, count down, pop when spent.
        item_sine  = 1'b1;
        phase_next = phase_adv;
        if (pop) begin
          head_next = ptr_inc(head);
          fill_next = fill - 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = head;
          wr_tone = '{step: head_tone.step, left: left_dec};
        end
      end
    end
  end

  qstg_ram #(
    .WIDTH (TONE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_tone),
    .raddr (head_next),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      phase     <= '0;
      fwd_hit   <= 1'b0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      head    <= head_next;
      tail    <= tail_next;
      fill    <= fill_next;
      phase   <= phase_next;
      // Remember a write that lands on the entry read this cycle.
      fwd_hit <= wr_en && (wr_addr == head_next);
      if (s1_open) begin
        s1_valid <= take;
      end
      if (s2_open) begin
        res_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_tone <= wr_tone;
    if (take) begin
      s1_idx      <= idx;
      s1_sine     <= item_sine;
      s1_accepted <= item_accepted;
      s1_playing  <= (fill_next != '0);
    end
    // Registered sine lookup into the output beat.
    if (s2_open && s1_valid) begin
      res.sample   <= s1_sine ? SINE_ROM[s1_idx] : '0;
      res.accepted <= s1_accepted;
      res.playing  <= s1_playing;
    end
  end

  `QSTG_CHECK_NOW(a_ptrs_meet, clk, rst, (fill == '0) || full, head == tail)
  `QSTG_CHECK_NOW(a_phase_range, clk, rst, 1'b1, 32'(phase) < SAMPLE_RATE)
  `QSTG_CHECK_NEXT(a_take_loads, clk, rst, take, s1_valid)
  `QSTG_CHECK_NEXT(a_reject_holds, clk, rst, take && is_push && full, $stable(fill) && $stable(tail))
  `QSTG_CHECK_NEXT(a_no_drop, clk, rst, s1_valid && res_valid && res_stall, s1_valid)

endmodule

`default_nettype wire

/* rtl/core/qstg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module qstg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for the queued sine tone generator: directed and random command beats, scoreboard.
`timescale 1ns / 1ps

import qstg_pkg::*;

// Predicts each result beat from the accepted command beats and checks the block against it.
class sine_tone_scoreboard;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

  shortint     sine_lut[SINE_TABLE_SIZE];
  int unsigned tone_step[QUEUE_DEPTH];
  int unsigned tone_left[QUEUE_DEPTH];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  int unsigned fill;
  int unsigned phase_acc;
  res_t        due_results[$];
  int          errors;

  function new();
    for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
      sine_lut[k] = sine_value(k);
    end
    head_ptr  = 0;
    tail_ptr  = 0;
    fill      = 0;
    phase_acc = 0;
    errors    = 0;
  endfunction

  // Fold into a quarter wave, run the Q30 Taylor series to x^13, scale.
  function shortint sine_value(int unsigned k);
    longint unsigned frac;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    logic [1:0]      quad;
    frac = (64'(k) << 32) / 64'(SINE_TABLE_SIZE);
    quad = frac[31:30];
    r    = frac & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    x    = (r * QUARTER_TURN_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = (64'(acc) * 64'(TONE_AMPLITUDE) + (64'd1 << 20)) >> 30;
    if (mag > 64'(TONE_AMPLITUDE)) begin
      mag = 64'(TONE_AMPLITUDE);
    end
    return quad[1] ? -shortint'(mag) : shortint'(mag);
  endfunction

  function void take_cmd(cmd_t c);
    res_t            want;
    longint unsigned n_samples;
    int unsigned     idx;
    want = '0;
    if (c.op == OP_PUSH) begin
      if (fill < QUEUE_DEPTH) begin
        n_samples = 64'(c.duration_ms) * 64'(SAMPLE_RATE) / 64'(MS_PER_SECOND);
        want.accepted = 1'b1;
        if (c.reset_phase) begin
          phase_acc = 0;
        end
        // zero-length tones are taken but never queued
        if (n_samples != 0) begin
          tone_step[tail_ptr] = 32'(c.tone_freq) % SAMPLE_RATE;
          tone_left[tail_ptr] = 32'(n_samples[21:0]);
          tail_ptr = (tail_ptr + 1) % QUEUE_DEPTH;
          fill++;
        end
      end
    end else if (fill != 0) begin
      idx = 32'(64'(phase_acc) * 64'(SINE_TABLE_SIZE) / 64'(SAMPLE_RATE));
      if (idx >= SINE_TABLE_SIZE) begin
        idx = SINE_TABLE_SIZE - 1;
      end
      want.sample = sine_lut[idx];
      phase_acc = (phase_acc + tone_step[head_ptr]) % SAMPLE_RATE;
      if (tone_left[head_ptr] != 0) begin
        tone_left[head_ptr]--;
      end
      if (tone_left[head_ptr] == 0) begin
        head_ptr = (head_ptr + 1) % QUEUE_DEPTH;
        fill--;
      end
    end
    want.playing = (fill != 0);
    due_results.push_back(want);
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected result beat: sample=%0d accepted=%0b playing=%0b",
                 got.sample, got.accepted, got.playing);
      end
      return;
    end
    want = due_results.pop_front();
    if (got.sample !== want.sample || got.accepted !== want.accepted ||
        got.playing !== want.playing) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b (sample/accepted/playing)",
                 want.sample, want.accepted, want.playing,
                 got.sample, got.accepted, got.playing);
      end
    end
  endfunction

  function int pending();
    return due_results.size();
  endfunction
endclass

module testbench;
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // Idle odds in percent for each side; the sender's is read only by the send task.
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  // A bump of hold_reqs asks the receiver process for one long hold-off.
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Samples still owed per queued tone, as the stimulus sees it; lets a
  // sequence play its tones out to silence without peeking at the scoreboard.
  int plan_left[$];
  int items_sent = 0;

  sine_tone_scoreboard sb = new();

  queued_sine_tone_generator_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 60;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Monitor: both channels are sampled at the edge that moves the beat.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        sb.take_cmd(cmd);
      end
      if (res_valid && !res_stall) begin
        sb.check_result(res);
      end
    end
  end

  // Offer one command beat, with random idle cycles first, and hold it until taken.
  task automatic send_item(input cmd_t c);
    int n;
    while ($urandom_range(99) < snd_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    items_sent++;
    // track the queue: full pushes are dropped, zero-length ones leave no entry
    if (c.op == OP_PUSH) begin
      if (plan_left.size() < QUEUE_DEPTH) begin
        n = int'(64'(c.duration_ms) * 64'(SAMPLE_RATE) / 64'(MS_PER_SECOND));
        if (n > 0) begin
          plan_left.push_back(n);
        end
      end
    end else if (plan_left.size() > 0) begin
      plan_left[0] = plan_left[0] - 1;
      if (plan_left[0] == 0) begin
        void'(plan_left.pop_front());
      end
    end
  endtask

  task automatic push_tone(input logic [FREQ_W-1:0] freq, input logic [DUR_W-1:0] dur,
                           input logic clear_phase);
    cmd_t c;
    c.op          = OP_PUSH;
    c.tone_freq   = freq;
    c.duration_ms = dur;
    c.reset_phase = clear_phase;
    send_item(c);
  endtask

  // Sample beats carry random junk in the push-only fields.
  task automatic play_sample();
    cmd_t c;
    c.op          = OP_SAMPLE;
    c.tone_freq   = FREQ_W'($urandom);
    c.duration_ms = DUR_W'($urandom);
    c.reset_phase = 1'($urandom_range(1));
    send_item(c);
  endtask

  // Short tones only, so the queue drains and wraps within the run.
  task automatic push_random();
    int                pick;
    logic [FREQ_W-1:0] f;
    logic [DUR_W-1:0]  d;
    pick = $urandom_range(99);
    d    = (pick < 20) ? DUR_W'(0) : (pick < 85) ? DUR_W'(1) : DUR_W'(2);
    pick = $urandom_range(99);
    f    = (pick < 5) ? FREQ_W'(0) : (pick < 10) ? '1 : FREQ_W'($urandom_range(32767));
    push_tone(f, d, 1'($urandom_range(1)));
  endtask

  // Mostly queue a few tones and play them out to silence; sometimes mix freely.
  task automatic run_phase(input int snd_pct, input int rcv_pct, input logic squeeze);
    int stop_at;
    int k;
    snd_idle_pct = snd_pct;
    rcv_idle_pct <= rcv_pct;
    if (squeeze) begin
      hold_reqs <= hold_reqs + 1;
    end
    stop_at = items_sent + 30;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(1, 3);
        repeat (k) push_random();
        while (plan_left.size() > 0) begin
          play_sample();
        end
        repeat ($urandom_range(2)) play_sample();
      end else begin
        repeat (6) begin
          if ($urandom_range(99) < 30) begin
            push_random();
          end else begin
            play_sample();
          end
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Silence from an empty queue, then a zero-length tone that only clears the phase.
    play_sample();
    push_tone('0, '0, 1'b1);
    play_sample();
    // Half the sample rate, then the largest frequency the field holds.
    push_tone(FREQ_W'(22050), DUR_W'(1), 1'b1);
    repeat (4) play_sample();
    push_tone('1, DUR_W'(1), 1'b0);
    push_tone(FREQ_W'(1), DUR_W'(2), 1'b0);
    // Fill the queue, then push into a full queue: dropped, phase must hold.
    repeat (5) push_tone(FREQ_W'($urandom_range(32767)), DUR_W'(1), 1'b0);
    push_tone(FREQ_W'(440), DUR_W'(1), 1'b1);
    push_tone('0, '0, 1'b1);
    repeat (3) play_sample();

    // Random part: slow receiver, then slow sender, then full speed with one long hold-off.
    run_phase(7, 59, 1'b0);
    run_phase(59, 7, 1'b0);
    run_phase(0, 0, 1'b1);

    // Long tones drive the upper duration bits and the widest sample counts.
    while (plan_left.size() > 0) begin
      play_sample();
    end
    push_tone(FREQ_W'($urandom_range(32767)), '1, 1'b1);
    push_tone(FREQ_W'($urandom_range(32767)), DUR_W'(16'h5555), 1'b0);
    push_tone(FREQ_W'($urandom_range(32767)), DUR_W'(16'hAAAA), 1'b0);
    repeat (6) play_sample();
    cmd_valid <= 1'b0;

    // Drain, then wait a while longer for stray beats to show up.
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
